[rtl/sst_pkg.sv]
// shared types, switch codes and store layout for the swing step sequencer
package sst_pkg;

	localparam int STORE_COLS = 19;
	localparam int STORE_ROWS = 6;
	localparam int CMDQ_DEPTH = 4;

	localparam logic [4:0] OPT1_COL   = 5'd16;
	localparam logic [4:0] OPT2_COL   = 5'd17;
	localparam logic [4:0] GLOBAL_COL = 5'd18;
	localparam logic [2:0] GLOBAL_ROW = 3'd4;

	localparam logic [1:0] SW_UP   = 2'd1;
	localparam logic [1:0] SW_DOWN = 2'd2;
	localparam logic [1:0] SW_MID  = 2'd3;

	localparam logic [15:0] SWING_MAX = 16'd45875;

	typedef struct packed {
		logic        is_load;
		logic        load_ok;
		logic [4:0]  col;
		logic [11:0] bits;
		logic [15:0] step;
		logic [15:0] swing;
	} cmd_t;

	function automatic logic [1:0] sw_at(input logic [11:0] bits, input logic [2:0] row);
		logic [11:0] sh;
		sh = bits >> {row, 1'b0};
		return (row < 3'(STORE_ROWS)) ? sh[1:0] : SW_MID;
	endfunction

endpackage

[rtl/sst_ram.sv]
// generic single write port ram with registered read
module sst_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 19
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/sst_cmdq.sv]
// short command queue between the front and back parts
module sst_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  sst_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd,
	output sst_pkg::cmd_t rd_cmd,
	output logic          avail
);

	localparam int PTR_W = $clog2(sst_pkg::CMDQ_DEPTH);
	localparam int CNT_W = $clog2(sst_pkg::CMDQ_DEPTH + 1);

	sst_pkg::cmd_t     entry_q [sst_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign full   = (count_q == CNT_W'(sst_pkg::CMDQ_DEPTH));
	assign avail  = (count_q != '0);
	assign rd_cmd = entry_q[rd_ptr_q];
	assign do_wr  = wr && !full;
	assign do_rd  = rd && avail;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(sst_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(sst_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/sst_front.sv]
// input side: accepts items, classifies loads and ticks, clamps swing
module sst_front (
	input  logic          push,
	input  logic          q_full,
	input  logic          operation,
	input  logic [4:0]    column_index,
	input  logic [11:0]   column_bits,
	input  logic [15:0]   phase_step,
	input  logic [15:0]   swing_amount,
	output logic          q_wr,
	output sst_pkg::cmd_t q_cmd
);

	assign q_wr = push && !q_full;

	always_comb begin
		q_cmd.is_load = operation;
		q_cmd.load_ok = (column_index < 5'(sst_pkg::STORE_COLS));
		q_cmd.col     = column_index;
		q_cmd.bits    = column_bits;
		q_cmd.step    = phase_step;
		q_cmd.swing   = (swing_amount > sst_pkg::SWING_MAX) ? sst_pkg::SWING_MAX : swing_amount;
	end

endmodule

[rtl/sst_back.sv]
// execution side: switch store, channel gate loop, phase wrap loop, result register
module sst_back #(
	parameter int CHANNELS        = 6,
	parameter int STEPS           = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [4:0]    cfg_data,
	input  logic          cmd_avail,
	input  sst_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          pop,
	output logic          empty,
	output logic [5:0]    gates,
	output logic          beat_led,
	output logic          bar_led,
	output logic [3:0]    current_step,
	output logic          current_bar
);

	localparam int PW = PHASE_FRAC_BITS + 2;
	localparam int SW = $clog2(STEPS);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW = $clog2(sst_pkg::STORE_COLS);
	localparam logic [PW-1:0] ONE  = PW'(1) << PHASE_FRAC_BITS;
	localparam logic [PW-1:0] HALF = PW'(1) << (PHASE_FRAC_BITS - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_GATE = 5'b00010,
		ST_LAST = 5'b00100,
		ST_WRAP = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                      state_q;
	logic [4:0]                  pl_q;
	logic [SW-1:0]               step_q;
	logic                        bar_q;
	logic [PW-1:0]               phase_q;
	logic [PW-1:0]               wrap_q;
	logic [PW-1:0]               stepfx_q;
	logic [SW-1:0]               cur_step_q;
	logic                        cur_bar_q;
	logic [CW-1:0]               ch_q;
	logic [CHANNELS-1:0]         gates_q;
	logic [11:0]                 opt1_q;
	logic [11:0]                 opt2_q;
	logic [11:0]                 glob_q;
	logic [sst_pkg::STORE_COLS-1:0] valid_q;
	logic [CW-1:0]               ch_s1;
	logic [2:0]                  row_s1;
	logic                        rd_ok_s1;
	logic                        eval_s1;
	logic                        out_valid_q;
	logic [5:0]                  out_gates_q;
	logic [3:0]                  out_step_q;
	logic                        out_bar_q;

	logic [PHASE_FRAC_BITS+15:0] step_ext;
	logic [PHASE_FRAC_BITS+15:0] swing_ext;
	logic [PW-1:0]               step_fx;
	logic [PW-1:0]               swing_fx;
	logic [PW-1:0]               wrap_new;
	logic                        ram_we;
	logic [11:0]                 rd_data;
	logic [2:0]                  ch_row;
	logic [2:0]                  row_sel;
	logic [1:0]                  s1;
	logic [1:0]                  s2;
	logic [1:0]                  g1;
	logic [3:0]                  step4;
	logic [5:0]                  half_sum;
	logic [4:0]                  col;
	logic                        en;
	logic                        rd_ok;
	logic [1:0]                  sw_rd;
	logic                        play;
	logic [4:0]                  step_inc;
	logic                        step_wrap;
	logic                        out_free;

	// q0.16 to phase format
	assign step_ext  = {cmd.step, {PHASE_FRAC_BITS{1'b0}}};
	assign swing_ext = {cmd.swing, {PHASE_FRAC_BITS{1'b0}}};
	assign step_fx   = PW'(step_ext[PHASE_FRAC_BITS+15:16]);
	assign swing_fx  = PW'(swing_ext[PHASE_FRAC_BITS+15:16]);
	assign wrap_new  = step_q[0] ? (ONE - swing_fx) : (ONE + swing_fx);

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_avail;
	assign ram_we   = cmd_pop && cmd.is_load && cmd.load_ok;
	assign out_free = !out_valid_q || pop;

	sst_ram #(
		.WIDTH(12),
		.DEPTH(sst_pkg::STORE_COLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cmd.col[AW-1:0]),
		.wdata(cmd.bits),
		.raddr(col[AW-1:0]),
		.rdata(rd_data)
	);

	// per channel column and row selection
	always_comb begin
		ch_row   = 3'(ch_q);
		s1       = sst_pkg::sw_at(opt1_q, ch_row);
		s2       = sst_pkg::sw_at(opt2_q, ch_row);
		g1       = sst_pkg::sw_at(glob_q, sst_pkg::GLOBAL_ROW);
		step4    = 4'(step_q);
		half_sum = 6'(step4) + (bar_q ? 6'(pl_q) : 6'd0);
		row_sel  = ch_row;
		if (s2 == sst_pkg::SW_DOWN) begin
			row_sel = (ch_row == 3'd0) ? 3'(CHANNELS - 1) : ch_row - 3'd1;
		end else if (s2 == sst_pkg::SW_UP) begin
			row_sel = (ch_row == 3'(CHANNELS - 1)) ? 3'd0 : ch_row + 3'd1;
		end
		en  = 1'b1;
		col = 5'(step4);
		if (g1 == sst_pkg::SW_MID && s1 == sst_pkg::SW_DOWN) begin
			col = {2'b00, step4[2:0]};
		end else if (g1 == sst_pkg::SW_MID && s1 == sst_pkg::SW_UP) begin
			col = {2'b01, step4[2:0]};
		end else if (g1 == sst_pkg::SW_UP && s1 == sst_pkg::SW_DOWN) begin
			col = half_sum[5:1];
		end else if (g1 == sst_pkg::SW_UP && s1 == sst_pkg::SW_UP) begin
			en = !bar_q;
		end
		rd_ok = en && (col < 5'(sst_pkg::STORE_COLS)) && valid_q[col[AW-1:0]];
	end

	// gate from the column read in the previous cycle
	always_comb begin
		sw_rd = rd_ok_s1 ? sst_pkg::sw_at(rd_data, row_s1) : sst_pkg::SW_MID;
		play  = (sw_rd != sst_pkg::SW_MID) && !(sw_rd == sst_pkg::SW_DOWN && phase_q >= HALF);
	end

	assign step_inc  = 5'(step_q) + 5'd1;
	assign step_wrap = (step_inc >= 5'(STEPS)) || (step_inc >= pl_q);

	always_ff @(posedge clk) begin
		ch_s1  <= ch_q;
		row_s1 <= row_sel;
		if (cmd_pop && !cmd.is_load) begin
			stepfx_q   <= step_fx;
			wrap_q     <= wrap_new;
			cur_step_q <= step_q;
			cur_bar_q  <= bar_q;
		end
		if (state_q == ST_DONE && out_free) begin
			out_gates_q <= 6'(gates_q);
			out_step_q  <= 4'(cur_step_q);
			out_bar_q   <= cur_bar_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pl_q        <= 5'd16;
			step_q      <= '0;
			bar_q       <= 1'b0;
			phase_q     <= '0;
			ch_q        <= '0;
			gates_q     <= '0;
			opt1_q      <= '1;
			opt2_q      <= '1;
			glob_q      <= '1;
			valid_q     <= '0;
			rd_ok_s1    <= 1'b0;
			eval_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pl_q <= cfg_data;
			end
			rd_ok_s1 <= rd_ok;
			eval_s1  <= (state_q == ST_GATE);
			if (eval_s1) begin
				gates_q[ch_s1] <= play;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_avail) begin
						if (cmd.is_load) begin
							if (cmd.load_ok) begin
								valid_q[cmd.col[AW-1:0]] <= 1'b1;
								if (cmd.col == sst_pkg::OPT1_COL) begin
									opt1_q <= cmd.bits;
								end
								if (cmd.col == sst_pkg::OPT2_COL) begin
									opt2_q <= cmd.bits;
								end
								if (cmd.col == sst_pkg::GLOBAL_COL) begin
									glob_q <= cmd.bits;
								end
							end
						end else begin
							ch_q    <= '0;
							gates_q <= '0;
							state_q <= ST_GATE;
						end
					end
				end
				ST_GATE: begin
					if (ch_q == CW'(CHANNELS - 1)) begin
						state_q <= ST_LAST;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_LAST: begin
					phase_q <= phase_q + stepfx_q;
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					if (phase_q >= wrap_q) begin
						phase_q <= phase_q - wrap_q;
						if (step_wrap) begin
							step_q <= '0;
							bar_q  <= !bar_q;
						end else begin
							step_q <= step_inc[SW-1:0];
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty        = !out_valid_q;
	assign gates        = out_gates_q;
	assign current_step = out_step_q;
	assign current_bar  = out_bar_q;
	assign beat_led     = (out_step_q[1:0] == 2'd0);
	assign bar_led      = !out_bar_q;

endmodule

[rtl/swing_step_sequencer_tick.sv]
// top level of the six-channel swing step sequencer
// Usage:
//  Input queue: drive the item fields with push high; the item transfers on a rising
//  edge with push high and full low. operation 1 loads column_bits into switch column
//  column_index (indexes above 18 are dropped), operation 0 is a time tick.
//  Result queue: a tick result sits on gates, beat_led, bar_led, current_step and
//  current_bar while empty is low and transfers on a rising edge with pop high.
//  Loads give no result. cfg_we writes cfg_data into the step count at once.
//  Flow: a four entry command queue sits between input and execution. A load is
//  executed in the idle state. A tick runs the channel loop, a phase add, then the
//  wrap loop until no phase wrap is left: the channel loop reads the switch RAM once
//  per channel, and the wrap loop does one subtract and compare per cycle.
//  Reset: every switch reads as middle, step, bar and phase are zero,
//  the step count is 16. No clearing pass is needed.
//  Stall: a result waits in its output register; execution holds the next finished
//  tick, items keep filling the command queue, and full rises when it is full.
module swing_step_sequencer_tick #(
	parameter int CHANNELS        = 6,
	parameter int STEPS           = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [4:0]  column_index,
	input  logic [11:0] column_bits,
	input  logic [15:0] phase_step,
	input  logic [15:0] swing_amount,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  gates,
	output logic        beat_led,
	output logic        bar_led,
	output logic [3:0]  current_step,
	output logic        current_bar,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data
);

	logic          q_wr;
	sst_pkg::cmd_t q_wr_cmd;
	logic          q_rd;
	sst_pkg::cmd_t q_rd_cmd;
	logic          q_avail;

	sst_front u_front (
		.push        (push),
		.q_full      (full),
		.operation   (operation),
		.column_index(column_index),
		.column_bits (column_bits),
		.phase_step  (phase_step),
		.swing_amount(swing_amount),
		.q_wr        (q_wr),
		.q_cmd       (q_wr_cmd)
	);

	sst_cmdq u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wr_cmd(q_wr_cmd),
		.full  (full),
		.rd    (q_rd),
		.rd_cmd(q_rd_cmd),
		.avail (q_avail)
	);

	sst_back #(
		.CHANNELS       (CHANNELS),
		.STEPS          (STEPS),
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.cmd_avail   (q_avail),
		.cmd         (q_rd_cmd),
		.cmd_pop     (q_rd),
		.pop         (pop),
		.empty       (empty),
		.gates       (gates),
		.beat_led    (beat_led),
		.bar_led     (bar_led),
		.current_step(current_step),
		.current_bar (current_bar)
	);

	a_pop_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_avail)
		else $error("command taken from an empty queue");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !full)
		else $error("command written into a full queue");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (5'(current_step) < 5'(STEPS)))
		else $error("result step beyond pattern");

	a_unused_gates_low: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((gates >> CHANNELS) == 6'd0))
		else $error("gate set for a missing channel");

endmodule

[dv/tb.sv]
// self-checking testbench for the swing step sequencer tick block
`timescale 1ns / 1ps

module tb;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;
	localparam logic [1:0] SW_BROKEN = 2'd0;
	localparam int CHANNELS = 6;
	localparam int STEPS = 16;
	localparam logic [17:0] ONE_PHASE = 18'h10000;
	localparam logic [17:0] HALF_PHASE = 18'h08000;
	localparam int QUIET_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 5000;

	typedef struct packed {
		logic [5:0] gates;
		logic       beat_led;
		logic       bar_led;
		logic [3:0] current_step;
		logic       current_bar;
	} tick_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        operation = OP_TICK;
	logic [4:0]  column_index = '0;
	logic [11:0] column_bits = '0;
	logic [15:0] phase_step = '0;
	logic [15:0] swing_amount = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [5:0]  gates;
	logic        beat_led;
	logic        bar_led;
	logic [3:0]  current_step;
	logic        current_bar;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_data = '0;

	// sequencer state as predicted
	logic [11:0] switch_cols [sst_pkg::STORE_COLS];
	int          pattern_len;
	int          seq_step;
	logic        seq_bar;
	logic [17:0] seq_phase;
	tick_out_t   expected_ticks [$];

	int  errors = 0;
	int  stuck_cycles = 0;
	bit  idle_on = 1'b1;
	bit  hold_request = 1'b0;

	swing_step_sequencer_tick dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.column_index (column_index),
		.column_bits  (column_bits),
		.phase_step   (phase_step),
		.swing_amount (swing_amount),
		.empty        (empty),
		.pop          (pop),
		.gates        (gates),
		.beat_led     (beat_led),
		.bar_led      (bar_led),
		.current_step (current_step),
		.current_bar  (current_bar),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [1:0] switch_code(input int row, input int column);
		if (row < 0 || row >= sst_pkg::STORE_ROWS || column < 0
				|| column >= sst_pkg::STORE_COLS)
			return sst_pkg::SW_MID;
		return switch_cols[column][2*row +: 2];
	endfunction

	function automatic void predict_item(input logic op, input logic [4:0] col,
			input logic [11:0] bits, input logic [15:0] pstep, input logic [15:0] swing);
		tick_out_t   r;
		logic [1:0]  global_sw;
		logic [1:0]  s1;
		logic [1:0]  s2;
		logic [1:0]  sw;
		logic [17:0] wrap;
		logic [17:0] swing_sat;
		int          row;
		int          column;
		bit          enabled;
		if (op == OP_LOAD) begin
			if (col < sst_pkg::STORE_COLS)
				switch_cols[col] = bits;
			return;
		end
		global_sw = switch_code(sst_pkg::GLOBAL_ROW, sst_pkg::GLOBAL_COL);
		r.gates = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			s1 = switch_code(ch, sst_pkg::OPT1_COL);
			s2 = switch_code(ch, sst_pkg::OPT2_COL);
			row = ch;
			if (s2 == sst_pkg::SW_DOWN)
				row = (ch == 0) ? CHANNELS - 1 : ch - 1;
			else if (s2 == sst_pkg::SW_UP)
				row = (ch == CHANNELS - 1) ? 0 : ch + 1;
			enabled = 1'b1;
			column = seq_step;
			if (global_sw == sst_pkg::SW_MID && s1 == sst_pkg::SW_DOWN) begin
				column = seq_step % 8;
			end else if (global_sw == sst_pkg::SW_MID && s1 == sst_pkg::SW_UP) begin
				column = seq_step % 8 + 8;
			end else if (global_sw == sst_pkg::SW_UP && s1 == sst_pkg::SW_DOWN) begin
				column = (seq_step + int'(seq_bar) * pattern_len) / 2;
			end else if (global_sw == sst_pkg::SW_UP && s1 == sst_pkg::SW_UP) begin
				enabled = !seq_bar;
			end
			sw = enabled ? switch_code(row, column) : sst_pkg::SW_MID;
			// down switch is a short note, cut in the second half of the step
			r.gates[ch] = (sw != sst_pkg::SW_MID)
				&& !(sw == sst_pkg::SW_DOWN && seq_phase >= HALF_PHASE);
		end
		r.beat_led = (seq_step % 4) == 0;
		r.bar_led = !seq_bar;
		r.current_step = 4'(seq_step);
		r.current_bar = seq_bar;
		expected_ticks.push_back(r);

		swing_sat = (swing > sst_pkg::SWING_MAX) ? 18'(sst_pkg::SWING_MAX) : 18'(swing);
		wrap = seq_step[0] ? ONE_PHASE - swing_sat : ONE_PHASE + swing_sat;
		seq_phase = seq_phase + 18'(pstep);
		while (seq_phase >= wrap) begin
			seq_phase = seq_phase - wrap;
			seq_step++;
			if (seq_step >= STEPS || seq_step >= pattern_len) begin
				seq_step = 0;
				seq_bar = !seq_bar;
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("tb: mismatch %s got %0d expected %0d", what, got, want);
	endtask

	// result side
	always @(posedge clk) begin
		tick_out_t want;
		if (arst_n && pop && !empty) begin
			if (expected_ticks.size() == 0) begin
				report_mismatch("unexpected result, gates", gates, 0);
			end else begin
				want = expected_ticks.pop_front();
				if (gates !== want.gates)
					report_mismatch("gates", gates, want.gates);
				if (beat_led !== want.beat_led)
					report_mismatch("beat_led", beat_led, want.beat_led);
				if (bar_led !== want.bar_led)
					report_mismatch("bar_led", bar_led, want.bar_led);
				if (current_step !== want.current_step)
					report_mismatch("current_step", current_step, want.current_step);
				if (current_bar !== want.current_bar)
					report_mismatch("current_bar", current_bar, want.current_bar);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic send_item(input logic op, input logic [4:0] col, input logic [11:0] bits,
			input logic [15:0] pstep, input logic [15:0] swing);
		push <= 1'b1;
		operation <= op;
		column_index <= col;
		column_bits <= bits;
		phase_step <= pstep;
		swing_amount <= swing;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_item(op, col, bits, pstep, swing);
	endtask

	task automatic send_tick(input logic [15:0] pstep, input logic [15:0] swing);
		send_item(OP_TICK, 5'($urandom), 12'($urandom), pstep, swing);
	endtask

	task automatic send_load(input logic [4:0] col, input logic [11:0] bits);
		send_item(OP_LOAD, col, bits, 16'($urandom), 16'($urandom));
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_random_item();
		logic        op;
		logic [4:0]  col;
		logic [15:0] pstep;
		logic [15:0] swing;
		op = ($urandom_range(0, 9) < 3) ? OP_LOAD : OP_TICK;
		col = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(19, 31))
			: 5'($urandom_range(0, sst_pkg::STORE_COLS - 1));
		case ($urandom_range(0, 3))
			0: pstep = 16'($urandom_range(0, 4000));
			1: pstep = 16'($urandom_range(16000, 40000));
			2: pstep = 16'($urandom);
			default: pstep = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
		swing = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, sst_pkg::SWING_MAX));
		send_item(op, col, 12'($urandom), pstep, swing);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_pattern_length(input logic [4:0] len);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		pattern_len = len;
	endtask

	task automatic run_random_traffic(input int count);
		for (int n = 0; n < count; n++) begin
			send_random_item();
			sender_gap();
		end
	endtask

	task automatic test_reset_state();
		send_tick(16'h0000, 16'h0000);
		send_tick(16'hFFFF, 16'hFFFF);
		send_tick(16'hFFFF, 16'h0000);
		send_tick(16'h1234, sst_pkg::SWING_MAX);
	endtask

	task automatic test_switch_codes();
		// rows: broken, up, down, mid, broken, up
		send_load(5'd0, {sst_pkg::SW_UP, SW_BROKEN, sst_pkg::SW_MID, sst_pkg::SW_DOWN,
			sst_pkg::SW_UP, SW_BROKEN});
		send_load(5'd1, {6{sst_pkg::SW_DOWN}});
		send_load(5'd2, {6{SW_BROKEN}});
		for (int n = 0; n < 6; n++)
			send_tick(16'h6000, 16'h0000);
	endtask

	task automatic test_ignored_loads();
		send_load(5'd19, 12'h000);
		send_load(5'd31, 12'h555);
		send_tick(16'h8000, 16'h0000);
	endtask

	task automatic test_channel_options();
		send_load(sst_pkg::OPT1_COL, {SW_BROKEN, sst_pkg::SW_MID, sst_pkg::SW_UP,
			sst_pkg::SW_DOWN, sst_pkg::SW_UP, sst_pkg::SW_DOWN});
		send_load(sst_pkg::OPT2_COL, {sst_pkg::SW_MID, sst_pkg::SW_MID, sst_pkg::SW_MID,
			sst_pkg::SW_MID, sst_pkg::SW_UP, sst_pkg::SW_DOWN});
		send_tick(16'hC000, 16'h4000);
		send_load(sst_pkg::GLOBAL_COL, {sst_pkg::SW_MID, sst_pkg::SW_UP, sst_pkg::SW_MID,
			sst_pkg::SW_MID, sst_pkg::SW_MID, sst_pkg::SW_MID});
		send_tick(16'hC000, 16'h4000);
		send_load(sst_pkg::GLOBAL_COL, {sst_pkg::SW_MID, sst_pkg::SW_DOWN, sst_pkg::SW_MID,
			sst_pkg::SW_MID, sst_pkg::SW_MID, sst_pkg::SW_MID});
		send_tick(16'hC000, 16'h4000);
	endtask

	task automatic test_pattern_lengths();
		logic [4:0] lengths [8];
		lengths = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'($urandom_range(2, 15)), 5'd8};
		foreach (lengths[k]) begin
			set_pattern_length(lengths[k]);
			run_random_traffic(120);
		end
	endtask

	task automatic test_backpressure();
		settle();
		hold_request = 1'b1;
		for (int n = 0; n < 24; n++)
			send_tick(16'($urandom), 16'($urandom_range(0, sst_pkg::SWING_MAX)));
		push <= 1'b0;
		while (hold_request) @(posedge clk);
		run_random_traffic(16);
	endtask

	task automatic test_sender_pause();
		run_random_traffic(12);
		push <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		run_random_traffic(18);
	endtask

	task automatic test_back_to_back();
		set_pattern_length(5'd16);
		idle_on = 1'b0;
		run_random_traffic(120);
	endtask

	initial begin
		foreach (switch_cols[c])
			switch_cols[c] = 12'hFFF;
		pattern_len = 16;
		seq_step = 0;
		seq_bar = 1'b0;
		seq_phase = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_switch_codes();
		test_ignored_loads();
		test_channel_options();
		test_pattern_lengths();
		test_backpressure();
		test_sender_pause();
		test_back_to_back();
		settle();
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

[swing_step_sequencer_tick.f]
rtl/sst_pkg.sv
rtl/sst_ram.sv
rtl/sst_cmdq.sv
rtl/sst_front.sv
rtl/sst_back.sv
rtl/swing_step_sequencer_tick.sv
dv/tb.sv
